// ===== rtl/cpra_pkg.sv =====
`timescale 1ns / 1ps

package cpra_pkg;

    localparam int PAGES_DEF    = 4096;
    localparam int REF_BITS_DEF = 8;
    localparam int SCAN_LIMIT   = 128 * 1024 / 4;

    localparam int FUNC_W  = 1;
    localparam int PAGE_W  = 12;
    localparam int RUN_W   = 13;
    localparam int VALUE_W = 8;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 16;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 1'b1;

    typedef struct packed {
        logic in_table;
        logic page_free;
        logic run_done;
        logic past_limit;
        logic last_page;
    } step_flags_t;

endpackage

// ===== rtl/cpra_ram.sv =====
`timescale 1ns / 1ps

module cpra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/cpra_step.sv =====
`timescale 1ns / 1ps

module cpra_step #(
    parameter int PAGES    = cpra_pkg::PAGES_DEF,
    parameter int REF_BITS = cpra_pkg::REF_BITS_DEF,
    parameter int PTR_W    = 13
) (
    input  logic [PTR_W-1:0]           ptr,
    input  logic [PTR_W-1:0]           cand,
    input  logic [cpra_pkg::RUN_W-1:0] cnt,
    input  logic [cpra_pkg::RUN_W-1:0] target,
    input  logic [REF_BITS-1:0]        data,
    output logic [PTR_W-1:0]           ptr_inc,
    output logic [cpra_pkg::RUN_W-1:0] cnt_inc,
    output logic [REF_BITS-1:0]        data_inc,
    output cpra_pkg::step_flags_t      flags
);

    import cpra_pkg::*;

    localparam int SCAN_END = (PAGES < SCAN_LIMIT) ? PAGES : SCAN_LIMIT;
    localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};

    logic [RUN_W:0] cnt_sum;

    assign ptr_inc  = ptr + PTR_W'(1);
    assign cnt_sum  = {1'b0, cnt} + (RUN_W + 1)'(1);
    assign cnt_inc  = cnt_sum[RUN_W-1:0];
    assign data_inc = (data == REF_MAX) ? data : data + REF_BITS'(1);

    always_comb
    begin
        flags.in_table   = (ptr < PTR_W'(PAGES));
        flags.page_free  = flags.in_table && (data == '0);
        flags.run_done   = (cnt_sum == {1'b0, target});
        flags.past_limit = (cand >= PTR_W'(SCAN_END));
        flags.last_page  = (ptr == PTR_W'(PAGES - 1));
    end

endmodule

// ===== rtl/contiguous_page_run_allocator.sv =====
`timescale 1ns / 1ps

// First-fit allocator of contiguous page runs over a per-page reference count store.
// Input transactions arrive on the s_ channel: s_tuser selects an allocation (0) or a
// direct count write (1). Each transaction yields exactly one result transaction on the
// m_ channel with a found flag and the first page of the run.
// After reset the block sweeps the count store to zero, one page per cycle, and accepts
// nothing until all PAGES entries (4096 by default) are cleared.
// One transaction is handled at a time; s_tready is high only while the block is idle.
// A count write passes S_DONE, which raises m_tvalid once the output register is free,
// and s_tready returns high in the same cycle as m_tvalid.
// An allocation walks the store through one shared step unit and one memory read port:
// every page examined from start_page passes S_SCAN_RD and S_SCAN_CHK, every page in the
// granted run whose count is incremented passes S_BUMP_RD and S_BUMP_WR, and S_DONE loads
// the result register; a search that finds no run ends on an S_SCAN_RD past the limit.
// The worst-case allocation time grows with PAGES.
// The result sits in an output register; if the receiver stalls, the block still takes
// and finishes the next transaction, then holds that result and stays busy until the
// output register is free.
module contiguous_page_run_allocator #(
    parameter int PAGES    = cpra_pkg::PAGES_DEF,
    parameter int REF_BITS = cpra_pkg::REF_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // start_page[11:0], run_length[24:12], page_index[36:25], ref_value[44:37]
    input  logic [cpra_pkg::S_TDATA_W-1:0] s_tdata,
    // func[0]
    input  logic [cpra_pkg::FUNC_W-1:0]    s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // found[0], first_page[12:1]
    output logic [cpra_pkg::M_TDATA_W-1:0] m_tdata
);

    import cpra_pkg::*;

    localparam int AW    = $clog2(PAGES);
    localparam int PTR_W = ((AW > PAGE_W) ? AW : PAGE_W) + 1;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_BUMP_RD,
        S_BUMP_WR,
        S_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   ptr_reg, ptr_next;
    logic [PTR_W-1:0]   cand_reg, cand_next;
    logic [RUN_W-1:0]   cnt_reg, cnt_next;
    logic [RUN_W-1:0]   len_reg, len_next;
    logic               found_reg, found_next;
    logic [PAGE_W-1:0]  first_reg, first_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic               out_found_reg, out_found_next;
    logic [PAGE_W-1:0]  out_first_reg, out_first_next;

    logic [PAGE_W-1:0]  in_start;
    logic [RUN_W-1:0]   in_len;
    logic [PAGE_W-1:0]  in_index;
    logic [VALUE_W-1:0] in_value;
    logic               accept;

    logic [PTR_W-1:0]    step_ptr;
    logic [RUN_W-1:0]    step_target;
    logic [PTR_W-1:0]    ptr_inc;
    logic [RUN_W-1:0]    cnt_inc;
    logic [REF_BITS-1:0] data_inc;
    step_flags_t         flags;

    logic                ram_we;
    logic [REF_BITS-1:0] ram_wdata;
    logic [REF_BITS-1:0] ram_rdata;
    logic [REF_BITS-1:0] value_sat;

    assign in_start = s_tdata[11:0];
    assign in_len   = s_tdata[24:12];
    assign in_index = s_tdata[36:25];
    assign in_value = s_tdata[44:37];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(M_TDATA_W - PAGE_W - 1)'(0), out_first_reg, out_found_reg};

    assign step_ptr    = (state_reg == S_IDLE) ? PTR_W'(in_index) : ptr_reg;
    assign step_target = (state_reg == S_SCAN_CHK && len_reg == '0) ? RUN_W'(1) : len_reg;

    assign value_sat = (32'(in_value) > 32'((1 << REF_BITS) - 1)) ? {REF_BITS{1'b1}}
                                                                    : REF_BITS'(in_value);

    cpra_step #(
        .PAGES    (PAGES),
        .REF_BITS (REF_BITS),
        .PTR_W    (PTR_W)
    ) u_step (
        .ptr      (step_ptr),
        .cand     (cand_reg),
        .cnt      (cnt_reg),
        .target   (step_target),
        .data     (ram_rdata),
        .ptr_inc  (ptr_inc),
        .cnt_inc  (cnt_inc),
        .data_inc (data_inc),
        .flags    (flags)
    );

    cpra_ram #(
        .WIDTH (REF_BITS),
        .DEPTH (PAGES)
    ) u_refs (
        .clk   (clk),
        .we    (ram_we),
        .waddr (step_ptr[AW-1:0]),
        .wdata (ram_wdata),
        .raddr (ptr_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        cand_next      = cand_reg;
        cnt_next       = cnt_reg;
        len_next       = len_reg;
        found_next     = found_reg;
        first_next     = first_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        out_found_next = out_found_reg;
        out_first_next = out_first_reg;
        ram_we         = 1'b0;
        ram_wdata      = '0;

        unique case (state_reg)
            S_CLR:
            begin
                ram_we = 1'b1;
                if (flags.last_page)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    ptr_next = ptr_inc;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    first_next = '0;
                    if (s_tuser == FUNC_WRITE)
                    begin
                        ram_we     = flags.in_table;
                        ram_wdata  = value_sat;
                        found_next = flags.in_table;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        found_next = 1'b0;
                        ptr_next   = PTR_W'(in_start);
                        cand_next  = PTR_W'(in_start);
                        cnt_next   = '0;
                        len_next   = in_len;
                        state_next = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD:
            begin
                if (cnt_reg == '0 && flags.past_limit)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                if (flags.page_free)
                begin
                    if (flags.run_done)
                    begin
                        found_next = 1'b1;
                        first_next = cand_reg[PAGE_W-1:0];
                        ptr_next   = cand_reg;
                        cnt_next   = '0;
                        state_next = (len_reg == '0) ? S_DONE : S_BUMP_RD;
                    end
                    else
                    begin
                        ptr_next   = ptr_inc;
                        cnt_next   = cnt_inc;
                        state_next = S_SCAN_RD;
                    end
                end
                else
                begin
                    ptr_next   = ptr_inc;
                    cand_next  = ptr_inc;
                    cnt_next   = '0;
                    state_next = S_SCAN_RD;
                end
            end
            S_BUMP_RD:
            begin
                state_next = S_BUMP_WR;
            end
            S_BUMP_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = data_inc;
                if (flags.run_done)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ptr_next   = ptr_inc;
                    cnt_next   = cnt_inc;
                    state_next = S_BUMP_RD;
                end
            end
            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next  = 1'b1;
                    out_found_next = found_reg;
                    out_first_next = first_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLR;
            ptr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ptr_reg      <= ptr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg      <= cand_next;
        cnt_reg       <= cnt_next;
        len_reg       <= len_next;
        found_reg     <= found_next;
        first_reg     <= first_next;
        out_found_reg <= out_found_next;
        out_first_reg <= out_first_next;
    end

`ifndef SYNTHESIS
    a_bump_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BUMP_WR) |-> (ptr_reg < PTR_W'(PAGES)))
        else $error("run increment outside the count store");

    a_bump_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BUMP_WR) |-> (cnt_reg < len_reg))
        else $error("run increment beyond the requested length");

    a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN_RD || state_reg == S_SCAN_CHK) |-> !ram_we)
        else $error("count store written during a scan");

    a_done_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_DONE))
        else $error("result issued outside the completion state");
`endif

endmodule

// ===== verif/contiguous_page_run_allocator_tb.sv =====
`timescale 1ns / 1ps

module contiguous_page_run_allocator_tb;

    import cpra_pkg::*;

    localparam int NUM_PAGES = PAGES_DEF;
    localparam int COUNT_MAX = (1 << REF_BITS_DEF) - 1;
    localparam int RANDOM_ITEMS = 1500;
    localparam int MAX_WAIT = 18;

    typedef struct {
        logic              found;
        logic [PAGE_W-1:0] first_page;
    } page_grant_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [FUNC_W-1:0]    s_tuser = FUNC_ALLOC;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    logic [REF_BITS_DEF-1:0] page_cnt [NUM_PAGES];
    page_grant_t             grant_q [$];
    int                      busy_q [$];
    int                      fail_count = 0;
    int                      alloc_total = 0;
    int                      alloc_granted = 0;
    int                      write_total = 0;

    contiguous_page_run_allocator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 clk = ~clk;

    function automatic logic page_is_free(input int p);
        if (p >= NUM_PAGES)
            return 1'b0;
        return page_cnt[p] == '0;
    endfunction

    function automatic page_grant_t predict_page_request(
        input logic [FUNC_W-1:0]  fn,
        input logic [PAGE_W-1:0]  start,
        input logic [RUN_W-1:0]   len,
        input logic [PAGE_W-1:0]  pidx,
        input logic [VALUE_W-1:0] val
    );
        page_grant_t res;
        int          i;
        int          j;
        int          lim;
        logic        done;
        res.found = 1'b0;
        res.first_page = '0;
        if (fn == FUNC_WRITE) begin
            write_total++;
            if (int'(pidx) < NUM_PAGES) begin
                page_cnt[pidx] = (int'(val) > COUNT_MAX) ? COUNT_MAX[REF_BITS_DEF-1:0] : val;
                res.found = 1'b1;
            end
            return res;
        end
        alloc_total++;
        lim = (NUM_PAGES < SCAN_LIMIT) ? NUM_PAGES : SCAN_LIMIT;
        i = int'(start);
        done = 1'b0;
        while (!done && i < lim) begin
            if (!page_is_free(i)) begin
                i++;
            end
            else begin
                j = 0;
                while (j < int'(len) && page_is_free(i + j))
                    j++;
                if (j == int'(len)) begin
                    for (int k = 0; k < int'(len); k++) begin
                        if (int'(page_cnt[i + k]) < COUNT_MAX)
                            page_cnt[i + k] = page_cnt[i + k] + 1'b1;
                        busy_q.push_back(i + k);
                    end
                    res.found = 1'b1;
                    res.first_page = i[PAGE_W-1:0];
                    alloc_granted++;
                    done = 1'b1;
                end
                else begin
                    i = i + j + 1;
                end
            end
        end
        return res;
    endfunction

    task automatic send_request(
        input logic [FUNC_W-1:0]  fn,
        input logic [PAGE_W-1:0]  start,
        input logic [RUN_W-1:0]   len,
        input logic [PAGE_W-1:0]  pidx,
        input logic [VALUE_W-1:0] val
    );
        int gap;
        gap = $urandom_range(0, MAX_WAIT);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= fn;
        s_tdata <= {{(S_TDATA_W - PAGE_W - RUN_W - PAGE_W - VALUE_W){1'b0}},
                    val, pidx, len, start};
        do
            @(posedge clk);
        while (!s_tready);
        grant_q.push_back(predict_page_request(fn, start, len, pidx, val));
    endtask

    task automatic send_alloc(input int start, input int len);
        send_request(FUNC_ALLOC, start[PAGE_W-1:0], len[RUN_W-1:0],
                     PAGE_W'($urandom), VALUE_W'($urandom));
    endtask

    task automatic send_write(input int pidx, input int val);
        send_request(FUNC_WRITE, PAGE_W'($urandom), RUN_W'($urandom),
                     pidx[PAGE_W-1:0], val[VALUE_W-1:0]);
    endtask

    initial begin
        page_grant_t exp_grant;
        int          stall;
        forever begin
            stall = $urandom_range(0, MAX_WAIT);
            if ($urandom_range(0, 3) == 0)
                stall = 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            if (grant_q.size() == 0) begin
                $error("result transaction with no pending request: m_tdata=%h", m_tdata);
                fail_count++;
            end
            else begin
                exp_grant = grant_q.pop_front();
                if (m_tdata[0] !== exp_grant.found) begin
                    $error("found: expected %0d, actual %0d", exp_grant.found, m_tdata[0]);
                    fail_count++;
                end
                if (m_tdata[PAGE_W:1] !== exp_grant.first_page) begin
                    $error("first_page: expected %0d, actual %0d",
                           exp_grant.first_page, m_tdata[PAGE_W:1]);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_count_writes();
        send_write(0, COUNT_MAX);
        send_write(NUM_PAGES - 1, 170);
        send_write(2730, 85);
        send_write(0, 0);
        send_write(NUM_PAGES - 1, 0);
        send_write(2730, 0);
    endtask

    task automatic test_first_fit_search();
        send_alloc(0, 1);
        send_alloc(0, 0);
        send_write(5, 7);
        send_alloc(3, 4);
        send_alloc(NUM_PAGES - 2, 3);
        send_alloc(NUM_PAGES - 1, 1);
        send_alloc(NUM_PAGES - 1, 0);
        send_alloc(100, (1 << RUN_W) - 1);
        send_write(0, 0);
        send_write(5, 0);
        for (int p = 6; p < 10; p++)
            send_write(p, 0);
        send_write(NUM_PAGES - 1, 0);
        busy_q.delete();
    endtask

    task automatic test_random_traffic();
        int pick;
        int len;
        int idx;
        int pg;
        int val;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30 || (pick < 90 && busy_q.size() == 0)) begin
                pick = $urandom_range(0, 99);
                if (pick < 88)
                    len = $urandom_range(1, 4);
                else if (pick < 98)
                    len = $urandom_range(0, 16);
                else
                    len = $urandom_range(NUM_PAGES + 1, (1 << RUN_W) - 1);
                send_alloc($urandom_range(0, NUM_PAGES - 1), len);
            end
            else if (pick < 90) begin
                idx = $urandom_range(0, busy_q.size() - 1);
                pg = busy_q[idx];
                busy_q.delete(idx);
                send_write(pg, 0);
            end
            else begin
                pg = $urandom_range(0, NUM_PAGES - 1);
                val = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, COUNT_MAX);
                if (val != 0)
                    busy_q.push_back(pg);
                send_write(pg, val);
            end
        end
    endtask

    task automatic test_drain_table();
        for (int p = 0; p < NUM_PAGES; p++) begin
            if (page_cnt[p] != '0)
                send_write(p, 0);
        end
        busy_q.delete();
    endtask

    task automatic test_whole_table();
        send_alloc(0, NUM_PAGES);
        send_alloc(0, 0);
        send_alloc(NUM_PAGES / 2, NUM_PAGES + 1);
        send_write(NUM_PAGES - 1, 0);
        send_alloc(4000, 2);
        send_alloc(4000, 1);
        send_alloc(NUM_PAGES - 1, 0);
    endtask

    initial begin
        for (int p = 0; p < NUM_PAGES; p++)
            page_cnt[p] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_count_writes();
        test_first_fit_search();
        test_random_traffic();
        test_drain_table();
        test_whole_table();
        s_tvalid <= 1'b0;
        while (grant_q.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("Run covered %0d allocation requests (%0d granted) and %0d count writes,",
                 alloc_total, alloc_granted, write_total);
        $display("including a full-table run, table-end bounds and empty-run requests.");
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #(20_000_000);
        $display("Timeout with %0d results still pending.", grant_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== contiguous_page_run_allocator.f =====
rtl/cpra_pkg.sv
rtl/cpra_ram.sv
rtl/cpra_step.sv
rtl/contiguous_page_run_allocator.sv
verif/contiguous_page_run_allocator_tb.sv
